[design/aip_pkg.sv]
package aip_pkg;

    // Parser phases.
    typedef enum logic [3:0] {
        PH_HEADER,
        PH_LEN,
        PH_NAME,
        PH_PAD,
        PH_META,
        PH_DONE
    } aip_phase_t;

    // Result kinds carried on the output tuser.
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_NAME   = 2'd1;
    localparam logic [1:0] KIND_ENTRY  = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    // Error codes.
    localparam logic [2:0] ERR_NONE         = 3'd0;
    localparam logic [2:0] ERR_SHORT_HEADER = 3'd1;
    localparam logic [2:0] ERR_BAD_MAGIC    = 3'd2;
    localparam logic [2:0] ERR_SHORT_LENGTH = 3'd3;
    localparam logic [2:0] ERR_SHORT_NAME   = 3'd4;
    localparam logic [2:0] ERR_SHORT_PAD    = 3'd5;
    localparam logic [2:0] ERR_SHORT_META   = 3'd6;

    // Magic bytes, first byte in the lowest bits.
    localparam logic [31:0] MAGIC_WORD = 32'h5F4B_5046;

    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_SLASH     = 8'h2F;
    localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z   = 8'h5A;
    localparam logic [7:0] CASE_OFFSET    = 8'h20;

    // Header length in bytes minus one, metadata length in bytes minus one.
    localparam logic [4:0] HEADER_LAST_BYTE = 5'd12;
    localparam logic [4:0] META_LAST_BYTE   = 5'd15;

    typedef struct packed {
        logic        data_end;
        logic [7:0]  data_byte;
    } aip_item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [31:0] format_version;
        logic [31:0] entry_count;
        logic [7:0]  name_byte;
        logic [7:0]  key_byte;
        logic [31:0] entry_index;
        logic [31:0] name_length;
        logic [63:0] timestamp;
        logic [31:0] data_size;
        logic [31:0] data_offset;
        logic [2:0]  error_code;
        logic        last;
    } aip_result_t;

    // Shifts one byte into the top of a little-endian assembled word.
    function automatic logic [31:0] shift_in32(input logic [31:0] r, input logic [7:0] b);
        shift_in32 = {b, r[31:8]};
    endfunction

    // Lookup normalization: backslash to slash, A-Z to a-z.
    function automatic logic [7:0] lookup_key(input logic [7:0] d);
        if (d == CHAR_BACKSLASH)
        begin
            lookup_key = CHAR_SLASH;
        end
        else if (d >= CHAR_UPPER_A && d <= CHAR_UPPER_Z)
        begin
            lookup_key = d + CASE_OFFSET;
        end
        else
        begin
            lookup_key = d;
        end
    endfunction

endpackage

[design/aip_in_stage.sv]
module aip_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,
    input  logic              s_tlast,
    output logic              item_valid,
    output aip_pkg::aip_item_t item,
    input  logic              item_take
);

    logic               valid_reg;
    aip_pkg::aip_item_t item_reg;

    // The register can refill in the same cycle in which its content is taken.
    assign s_tready   = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.data_byte <= s_tdata;
            item_reg.data_end  <= s_tlast;
        end
    end

endmodule

[design/aip_parse_core.sv]
module aip_parse_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  aip_pkg::aip_item_t   item,
    output logic                 res_valid,
    output aip_pkg::aip_result_t res
);

    aip_pkg::aip_phase_t phase_reg, phase_next;
    logic [4:0]  fbc_reg, fbc_next;
    logic [31:0] version_reg, version_next;
    logic        decode_reg, decode_next;
    logic [31:0] entries_left_reg, entries_left_next;
    logic [31:0] cur_entry_reg, cur_entry_next;
    logic [31:0] name_left_reg, name_left_next;
    logic [31:0] cur_len_reg, cur_len_next;
    logic [1:0]  pad_left_reg, pad_left_next;
    logic [63:0] time_reg, time_next;
    logic [31:0] size_reg, size_next;
    logic [31:0] offset_reg, offset_next;
    logic        magic_bad_reg, magic_bad_next;
    logic [2:0]  end_code;
    logic [7:0]  decoded;
    logic [7:0]  b;

    assign b = item.data_byte;

    always_comb
    begin
        phase_next        = phase_reg;
        fbc_next          = fbc_reg;
        version_next      = version_reg;
        decode_next       = decode_reg;
        entries_left_next = entries_left_reg;
        cur_entry_next    = cur_entry_reg;
        name_left_next    = name_left_reg;
        cur_len_next      = cur_len_reg;
        pad_left_next     = pad_left_reg;
        time_next         = time_reg;
        size_next         = size_reg;
        offset_next       = offset_reg;
        magic_bad_next    = magic_bad_reg;
        res_valid         = 1'b0;
        res               = '0;
        end_code          = aip_pkg::ERR_NONE;
        decoded           = decode_reg ? (b - 8'd1) : b;

        if (fire)
        begin
            if (item.data_end)
            begin
                case (phase_reg)
                    aip_pkg::PH_HEADER:
                        end_code = (fbc_reg != 5'd0) ? aip_pkg::ERR_SHORT_HEADER
                                                     : aip_pkg::ERR_NONE;
                    aip_pkg::PH_LEN:  end_code = aip_pkg::ERR_SHORT_LENGTH;
                    aip_pkg::PH_NAME: end_code = aip_pkg::ERR_SHORT_NAME;
                    aip_pkg::PH_PAD:  end_code = aip_pkg::ERR_SHORT_PAD;
                    aip_pkg::PH_META: end_code = aip_pkg::ERR_SHORT_META;
                    default:          end_code = aip_pkg::ERR_NONE;
                endcase
                if (end_code != aip_pkg::ERR_NONE)
                begin
                    res_valid       = 1'b1;
                    res.result_kind = aip_pkg::KIND_ERROR;
                    res.entry_index = (phase_reg == aip_pkg::PH_HEADER) ? 32'd0 : cur_entry_reg;
                    res.error_code  = end_code;
                    res.last        = 1'b1;
                end
                // End of stream always brings the parser back to idle.
                phase_next        = aip_pkg::PH_HEADER;
                fbc_next          = '0;
                version_next      = '0;
                decode_next       = 1'b0;
                entries_left_next = '0;
                cur_entry_next    = '0;
                name_left_next    = '0;
                cur_len_next      = '0;
                pad_left_next     = '0;
                time_next         = '0;
                size_next         = '0;
                offset_next       = '0;
                magic_bad_next    = 1'b0;
            end
            else
            begin
                case (phase_reg)
                    aip_pkg::PH_HEADER:
                    begin
                        if (fbc_reg < 5'd4)
                        begin
                            version_next = aip_pkg::shift_in32(version_reg, b);
                        end
                        else if (fbc_reg < 5'd8)
                        begin
                            if (b != aip_pkg::MAGIC_WORD[8*fbc_reg[1:0] +: 8])
                            begin
                                magic_bad_next = 1'b1;
                            end
                        end
                        else if (fbc_reg == 5'd8)
                        begin
                            decode_next = (b == 8'd1);
                        end
                        else
                        begin
                            entries_left_next = aip_pkg::shift_in32(entries_left_reg, b);
                        end

                        if (fbc_reg < aip_pkg::HEADER_LAST_BYTE)
                        begin
                            fbc_next = fbc_reg + 5'd1;
                        end
                        else
                        begin
                            fbc_next  = '0;
                            res_valid = 1'b1;
                            if (magic_bad_reg)
                            begin
                                phase_next      = aip_pkg::PH_DONE;
                                res.result_kind = aip_pkg::KIND_ERROR;
                                res.error_code  = aip_pkg::ERR_BAD_MAGIC;
                                res.last        = 1'b1;
                            end
                            else
                            begin
                                res.result_kind    = aip_pkg::KIND_HEADER;
                                res.format_version = version_reg;
                                res.entry_count    = entries_left_next;
                                res.last           = (entries_left_next == 32'd0);
                                cur_entry_next     = '0;
                                phase_next = (entries_left_next == 32'd0) ? aip_pkg::PH_DONE
                                                                          : aip_pkg::PH_LEN;
                            end
                        end
                    end

                    aip_pkg::PH_LEN:
                    begin
                        cur_len_next = aip_pkg::shift_in32(cur_len_reg, b);
                        if (fbc_reg < 5'd3)
                        begin
                            fbc_next = fbc_reg + 5'd1;
                        end
                        else
                        begin
                            fbc_next       = '0;
                            name_left_next = cur_len_next;
                            pad_left_next  = 2'd0 - cur_len_next[1:0];
                            if (cur_len_next == 32'd0)
                            begin
                                phase_next = (pad_left_next != 2'd0) ? aip_pkg::PH_PAD
                                                                     : aip_pkg::PH_META;
                            end
                            else
                            begin
                                phase_next = aip_pkg::PH_NAME;
                            end
                        end
                    end

                    aip_pkg::PH_NAME:
                    begin
                        res_valid       = 1'b1;
                        res.result_kind = aip_pkg::KIND_NAME;
                        res.name_byte   = decoded;
                        res.key_byte    = aip_pkg::lookup_key(decoded);
                        res.entry_index = cur_entry_reg;
                        res.name_length = cur_len_reg;
                        name_left_next  = name_left_reg - 32'd1;
                        if (name_left_reg == 32'd1)
                        begin
                            fbc_next   = '0;
                            phase_next = (pad_left_reg != 2'd0) ? aip_pkg::PH_PAD
                                                                : aip_pkg::PH_META;
                        end
                    end

                    aip_pkg::PH_PAD:
                    begin
                        pad_left_next = pad_left_reg - 2'd1;
                        if (pad_left_reg == 2'd1)
                        begin
                            fbc_next   = '0;
                            phase_next = aip_pkg::PH_META;
                        end
                    end

                    aip_pkg::PH_META:
                    begin
                        if (fbc_reg < 5'd8)
                        begin
                            time_next = {b, time_reg[63:8]};
                        end
                        else if (fbc_reg < 5'd12)
                        begin
                            size_next = aip_pkg::shift_in32(size_reg, b);
                        end
                        else
                        begin
                            offset_next = aip_pkg::shift_in32(offset_reg, b);
                        end

                        if (fbc_reg < aip_pkg::META_LAST_BYTE)
                        begin
                            fbc_next = fbc_reg + 5'd1;
                        end
                        else
                        begin
                            fbc_next          = '0;
                            res_valid         = 1'b1;
                            res.result_kind   = aip_pkg::KIND_ENTRY;
                            res.entry_index   = cur_entry_reg;
                            res.name_length   = cur_len_reg;
                            res.timestamp     = time_next;
                            res.data_size     = size_next;
                            res.data_offset   = offset_next;
                            res.last          = (entries_left_reg == 32'd1);
                            entries_left_next = entries_left_reg - 32'd1;
                            cur_entry_next    = cur_entry_reg + 32'd1;
                            cur_len_next      = '0;
                            phase_next = (entries_left_reg == 32'd1) ? aip_pkg::PH_DONE
                                                                     : aip_pkg::PH_LEN;
                        end
                    end

                    default:
                    begin
                        // Trailing bytes after the archive or an error are dropped.
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= aip_pkg::PH_HEADER;
            fbc_reg          <= '0;
            version_reg      <= '0;
            decode_reg       <= 1'b0;
            entries_left_reg <= '0;
            cur_entry_reg    <= '0;
            name_left_reg    <= '0;
            cur_len_reg      <= '0;
            pad_left_reg     <= '0;
            time_reg         <= '0;
            size_reg         <= '0;
            offset_reg       <= '0;
            magic_bad_reg    <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            fbc_reg          <= fbc_next;
            version_reg      <= version_next;
            decode_reg       <= decode_next;
            entries_left_reg <= entries_left_next;
            cur_entry_reg    <= cur_entry_next;
            name_left_reg    <= name_left_next;
            cur_len_reg      <= cur_len_next;
            pad_left_reg     <= pad_left_next;
            time_reg         <= time_next;
            size_reg         <= size_next;
            offset_reg       <= offset_next;
            magic_bad_reg    <= magic_bad_next;
        end
    end

    // A header record only comes out of the header phase.
    a_header_from_header: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.result_kind == aip_pkg::KIND_HEADER) |-> phase_reg == aip_pkg::PH_HEADER)
        else $error("header record outside header phase");

    // Once done, only the end of the stream leaves the done phase.
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == aip_pkg::PH_DONE && !(fire && item.data_end)) |=>
        phase_reg == aip_pkg::PH_DONE)
        else $error("left done phase without end of stream");

    // The byte counter never passes the longest field group.
    a_fbc_range: assert property (@(posedge clk) disable iff (!rst_n)
        fbc_reg <= aip_pkg::META_LAST_BYTE)
        else $error("field byte counter out of range");

    // The name phase is never entered with no name bytes left.
    a_name_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == aip_pkg::PH_NAME |-> name_left_reg != 32'd0)
        else $error("name phase with zero bytes left");

endmodule

[design/aip_out_stage.sv]
module aip_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 res_valid,
    input  aip_pkg::aip_result_t res,
    output logic                 res_ready,
    output logic                 out_valid,
    output aip_pkg::aip_result_t out_res,
    input  logic                 out_ready
);

    logic                 main_valid_reg;
    logic                 skid_valid_reg;
    aip_pkg::aip_result_t main_reg;
    aip_pkg::aip_result_t skid_reg;
    logic                 main_free;

    // Ready depends only on the skid register, so no path runs from the output ready.
    assign res_ready = !skid_valid_reg;
    assign main_free = !main_valid_reg || out_ready;
    assign out_valid = main_valid_reg;
    assign out_res   = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (main_free)
        begin
            main_valid_reg <= skid_valid_reg || (res_valid && res_ready);
            skid_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (main_free)
        begin
            main_reg <= skid_valid_reg ? skid_reg : res;
        end
        else if (res_valid && res_ready)
        begin
            skid_reg <= res;
        end
    end

    // The skid register is only in use while the main register holds a stalled result.
    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid register valid with empty main register");

    // A stalled result is replaced only after it was taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (main_valid_reg && !out_ready) |=> main_valid_reg)
        else $error("stalled result dropped");

endmodule

[design/archive_index_parser_top.sv]
// Archive index parser.
// The input stream (s_*) carries one index byte per transaction in s_tdata[7:0];
// a transaction with s_tlast high marks the end of the stream and carries no byte.
// The output stream (m_*) carries at most one result per input transaction:
// a header record, a decoded name byte with its lookup byte, an entry record or
// an error. m_tuser holds the result kind and m_tlast marks the final result of
// an archive (empty header, last entry record, or any error).
// An accepted byte waits in the input register until the parse step takes it;
// its result is registered in the main output register and offered on m_tvalid.
// Throughput: one transaction per cycle while the output side has room, set by
// the single-pass parse step between the input register and the result register.
// When the receiver stalls, a two-entry output register (main plus skid) keeps
// the input side running for one more result; then s_tready drops until the
// receiver takes a result. s_tready never depends combinationally on m_tready.
// Reset clears all parser state to the idle header phase and empties both the
// input register and the output registers.
module archive_index_parser_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tlast,   // stream_end
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [279:0] m_tdata,   // [31:0] format_version, [63:32] entry_count,
                                    // [71:64] name_byte, [79:72] key_byte,
                                    // [111:80] entry_index, [143:112] name_length,
                                    // [207:144] timestamp, [239:208] data_size,
                                    // [271:240] data_offset, [274:272] error_code,
                                    // [279:275] zero
    output logic [1:0]   m_tuser,   // [1:0] result_kind
    output logic         m_tlast    // last
);

    logic                 item_valid;
    aip_pkg::aip_item_t   item;
    logic                 res_valid;
    logic                 res_ready;
    logic                 fire;
    aip_pkg::aip_result_t res;
    aip_pkg::aip_result_t out_res;

    // A buffered byte is parsed whenever the output side has room for a result.
    assign fire = item_valid && res_ready;

    aip_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (fire)
    );

    aip_parse_core u_parse_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    aip_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .out_valid (m_tvalid),
        .out_res   (out_res),
        .out_ready (m_tready)
    );

    assign m_tdata = {5'd0,
                      out_res.error_code,
                      out_res.data_offset,
                      out_res.data_size,
                      out_res.timestamp,
                      out_res.name_length,
                      out_res.entry_index,
                      out_res.key_byte,
                      out_res.name_byte,
                      out_res.entry_count,
                      out_res.format_version};
    assign m_tuser = out_res.result_kind;
    assign m_tlast = out_res.last;

endmodule
